// ===== src/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, constants and helpers of the integer text parser.
// ----------------------------------------------------------------------------
package itp_pkg;

   localparam int WORD_BITS   = 64;
   localparam int OFFSET_BITS = 16;
   localparam int RADIX_W     = 6;
   localparam int PROD_W      = WORD_BITS + RADIX_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [WORD_BITS-1:0]   WORD_MASK = '1;
   localparam logic [WORD_BITS-1:0]   SMAX      = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0]   SMIN      = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [OFFSET_BITS-1:0] OFF_MAX   = '1;

   localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
   localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
   localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

   localparam logic [7:0] UPPER_BIAS = 8'd55;   // 'A' - 10
   localparam logic [7:0] LOWER_BIAS = 8'd87;   // 'a' - 10

   localparam logic CSR_RADIX  = 1'b0;
   localparam logic CSR_SIGNED = 1'b1;

   typedef enum logic [2:0] {
      PH_SKIP,
      PH_PREFIX,
      PH_ZERO,
      PH_HEXFIRST,
      PH_DIGITS
   } phase_type;

   typedef enum logic [1:0] {
      DS_NONE,
      DS_SEEN,
      DS_OVF
   } digit_status_type;

   typedef struct packed {
      logic       start;
      logic       space;
      logic       plus;
      logic       minus;
      logic       zero;
      logic       hex_x;
      logic       alnum;
      logic [5:0] digit;
   } char_class_type;

   typedef struct packed {
      logic                 full;
      logic                 empty;
      logic [QCNT_BITS-1:0] count;
   } queue_status_type;

   function automatic logic digit_ok(char_class_type c, logic [RADIX_W-1:0] base);
      return c.alnum && (base >= RADIX_MIN) && (base <= RADIX_MAX) && (c.digit < base);
   endfunction

endpackage

// ===== src/itp_front.sv =====
// ----------------------------------------------------------------------------
// itp_front
// Accepts character words and classifies them for the parse engine.
// ----------------------------------------------------------------------------
module itp_front import itp_pkg::*; (
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_ch,
   input  logic             req_start_req,
   input  queue_status_type q_stat,
   output logic             q_push,
   output char_class_type   q_wdata
);

   logic [7:0] raw_digit;

   assign req_ready = !q_stat.full;
   assign q_push    = req_valid && !q_stat.full;

   always_comb begin
      q_wdata       = '0;
      q_wdata.start = req_start_req;
      q_wdata.space = (req_ch == 8'h20) || (req_ch >= 8'h09 && req_ch <= 8'h0D);
      q_wdata.plus  = (req_ch == 8'h2B);
      q_wdata.minus = (req_ch == 8'h2D);
      q_wdata.zero  = (req_ch == 8'h30);
      q_wdata.hex_x = (req_ch == 8'h78) || (req_ch == 8'h58);
      raw_digit     = 8'd0;
      if (req_ch >= 8'h30 && req_ch <= 8'h39) begin
         q_wdata.alnum = 1'b1;
         raw_digit     = req_ch - 8'h30;
      end else if (req_ch >= 8'h41 && req_ch <= 8'h5A) begin
         q_wdata.alnum = 1'b1;
         raw_digit     = req_ch - UPPER_BIAS;
      end else if (req_ch >= 8'h61 && req_ch <= 8'h7A) begin
         q_wdata.alnum = 1'b1;
         raw_digit     = req_ch - LOWER_BIAS;
      end
      q_wdata.digit = raw_digit[5:0];
   end

endmodule

// ===== src/itp_queue.sv =====
// ----------------------------------------------------------------------------
// itp_queue
// Short queue of classified characters between front and parse engine.
// ----------------------------------------------------------------------------
module itp_queue import itp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_push,
   input  char_class_type   q_wdata,
   input  logic             q_pop,
   output char_class_type   q_rdata,
   output queue_status_type q_stat
);

   char_class_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   function automatic logic [QPTR_BITS-1:0] ptr_next(logic [QPTR_BITS-1:0] p);
      return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = q_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = q_pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (q_push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!q_push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         entry_ff[wr_ptr_ff] <= q_wdata;
      end
   end

   assign q_rdata      = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign q_stat.count = count_ff;

endmodule

// ===== src/itp_back.sv =====
// ----------------------------------------------------------------------------
// itp_back
// Parse engine: phase tracking, base selection, digit accumulation with
// saturation, and the result register.
// ----------------------------------------------------------------------------
module itp_back import itp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  char_class_type   q_rdata,
   input  queue_status_type q_stat,
   output logic             q_pop,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [5:0]       csr_wdata,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [63:0]      rsp_value,
   output logic             rsp_range_error,
   output logic [15:0]      rsp_end_offset
);

   logic [RADIX_W-1:0]     radix_ff;
   logic                   signed_ff;

   phase_type              phase_ff, phase_in;
   logic                   neg_ff, neg_in;
   logic [RADIX_W-1:0]     base_ff, base_in;
   logic [WORD_BITS-1:0]   acc_ff, acc_in;
   digit_status_type       ds_ff, ds_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic                   fin_ff, fin_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [63:0]            value_ff, value_in;
   logic                   range_ff, range_in;
   logic [15:0]            endoff_ff, endoff_in;

   logic                   done;
   logic                   fire;
   logic [OFFSET_BITS-1:0] end_pos;
   logic [WORD_BITS-1:0]   acc_cur;
   logic [WORD_BITS-1:0]   limit;
   logic [PROD_W-1:0]      prod_sum;
   logic [WORD_BITS-1:0]   res_word;

   assign q_pop = !q_stat.empty && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff  <= RADIX_DEC;
         signed_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RADIX:  radix_ff  <= csr_wdata;
            CSR_SIGNED: signed_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // multiplier operands follow the start clear
   assign acc_cur  = q_rdata.start ? '0 : acc_ff;

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      base_in  = base_ff;
      acc_in   = acc_ff;
      ds_in    = ds_ff;
      off_in   = off_ff;
      fin_in   = fin_ff;
      done     = 1'b0;
      fire     = 1'b0;
      end_pos  = off_ff;
      limit    = '0;
      prod_sum = '0;
      if (q_pop) begin
         if (q_rdata.start) begin
            phase_in = PH_SKIP;
            neg_in   = 1'b0;
            base_in  = '0;
            acc_in   = '0;
            ds_in    = DS_NONE;
            off_in   = '0;
            fin_in   = 1'b0;
         end
         end_pos = off_in;
         if (!fin_in) begin
            if (phase_in == PH_SKIP) begin
               if (q_rdata.space) begin
                  done = 1'b1;
               end else if (q_rdata.plus || q_rdata.minus) begin
                  neg_in   = q_rdata.minus;
                  phase_in = PH_PREFIX;
                  done     = 1'b1;
               end else begin
                  phase_in = PH_PREFIX;
               end
            end
            if (!done && phase_in == PH_PREFIX) begin
               if (q_rdata.zero && (radix_ff == RADIX_AUTO || radix_ff == RADIX_HEX)) begin
                  acc_in   = '0;
                  ds_in    = DS_SEEN;
                  phase_in = PH_ZERO;
                  done     = 1'b1;
               end else begin
                  base_in  = (radix_ff == RADIX_AUTO) ? RADIX_DEC : radix_ff;
                  phase_in = PH_DIGITS;
               end
            end
            if (!done && phase_in == PH_ZERO) begin
               if (q_rdata.hex_x) begin
                  base_in  = RADIX_HEX;
                  phase_in = PH_HEXFIRST;
                  done     = 1'b1;
               end else begin
                  base_in  = (radix_ff == RADIX_AUTO) ? RADIX_OCT : radix_ff;
                  phase_in = PH_DIGITS;
               end
            end
            if (!done && phase_in == PH_HEXFIRST) begin
               if (!digit_ok(q_rdata, base_in)) begin
                  fire    = 1'b1;
                  end_pos = (off_in == OFF_MAX) ? off_in : off_in - 1'b1;
                  done    = 1'b1;
               end else begin
                  phase_in = PH_DIGITS;
               end
            end
            if (!done) begin
               limit    = signed_ff ? (neg_in ? SMIN : SMAX) : WORD_MASK;
               prod_sum = PROD_W'(acc_cur) * PROD_W'(base_in) + PROD_W'(q_rdata.digit);
               if (!digit_ok(q_rdata, base_in)) begin
                  fire = 1'b1;
               end else if (ds_in != DS_OVF) begin
                  if (prod_sum > PROD_W'(limit)) begin
                     ds_in = DS_OVF;
                  end else begin
                     ds_in  = DS_SEEN;
                     acc_in = prod_sum[WORD_BITS-1:0];
                  end
               end
            end
            if (fire) begin
               fin_in = 1'b1;
            end
            if (off_in != OFF_MAX) begin
               off_in = off_in + 1'b1;
            end
         end
      end
   end

   always_comb begin
      res_word  = '0;
      range_in  = 1'b0;
      endoff_in = '0;
      case (ds_in)
         DS_OVF: begin
            range_in  = 1'b1;
            res_word  = signed_ff ? (neg_in ? SMIN : SMAX) : WORD_MASK;
            endoff_in = 16'(end_pos);
         end
         DS_SEEN: begin
            res_word  = neg_in ? (WORD_BITS'(0) - acc_in) : acc_in;
            endoff_in = 16'(end_pos);
         end
         default: ;
      endcase
      if (signed_ff && res_word[WORD_BITS-1]) begin
         value_in = ~64'(WORD_MASK) | 64'(res_word);
      end else begin
         value_in = 64'(res_word);
      end
      rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SKIP;
         neg_ff       <= 1'b0;
         base_ff      <= '0;
         acc_ff       <= '0;
         ds_ff        <= DS_NONE;
         off_ff       <= '0;
         fin_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         base_ff      <= base_in;
         acc_ff       <= acc_in;
         ds_ff        <= ds_in;
         off_ff       <= off_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         value_ff  <= value_in;
         range_ff  <= range_in;
         endoff_ff <= endoff_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = value_ff;
   assign rsp_range_error = range_ff;
   assign rsp_end_offset  = endoff_ff;

endmodule

// ===== src/integer_text_parser.sv =====
// ----------------------------------------------------------------------------
// integer_text_parser
// Streaming integer parser: one character word in, at most one result per string.
//
// req_* carries one character per word; req_start_req marks the first
// character of a new string. Leading whitespace, an optional sign and an
// optional 0x prefix are taken; parsing ends at the first non-digit and
// yields one rsp_* word (value, range_error, end_offset). Characters that
// arrive after a string has ended and before the next start are dropped.
// csr_* writes radix (index 0) and signed_mode (index 1), idle only.
// Throughput: one character per cycle while no result waits on rsp_ready.
// The front classifies and writes a two-word queue; the engine retires one
// queued character per cycle with a single multiply-add (accumulator times
// base) and a limit compare. The result is registered once the terminating
// character leaves the queue. While a result waits with rsp_ready low, it
// holds, the engine stalls, and req_ready drops once the queue fills.
// Reset: radix 10, signed mode, queue empty, parser idle until a start.
// ----------------------------------------------------------------------------
module integer_text_parser import itp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_start_req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value,
   output logic        rsp_range_error,
   output logic [15:0] rsp_end_offset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [5:0]  csr_wdata
);

   queue_status_type q_stat;
   char_class_type   q_wdata;
   char_class_type   q_rdata;
   logic             q_push;
   logic             q_pop;

   itp_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_ch        (req_ch),
      .req_start_req (req_start_req),
      .q_stat        (q_stat),
      .q_push        (q_push),
      .q_wdata       (q_wdata)
   );

   itp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .q_pop   (q_pop),
      .q_rdata (q_rdata),
      .q_stat  (q_stat)
   );

   itp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_rdata         (q_rdata),
      .q_stat          (q_stat),
      .q_pop           (q_pop),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value       (rsp_value),
      .rsp_range_error (rsp_range_error),
      .rsp_end_offset  (rsp_end_offset)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_queue_push_ok: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("push into full queue");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |->
         (rsp_value == 64'(WORD_MASK)) || (rsp_value == (~64'(WORD_MASK) | 64'(SMIN)))
         || (rsp_value == 64'(SMAX)))
      else $error("range error without saturated value");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid && q_stat.empty)
      else $error("result or queue busy after reset");

endmodule

// ===== verif/tb_integer_text_parser.sv =====
// ----------------------------------------------------------------------------
// tb_integer_text_parser
// Self-checking bench for the streaming integer text parser.
//
// A queue of character words feeds a clocked driver. Each accepted word runs
// through a cycle-free model of the parser (whitespace, sign, base prefix,
// digits, saturation, offset), and every result word is checked field by field
// against the oldest predicted number. The run walks through several radix and
// sign settings, three idling regimes, a long result stall and a drained pause.
// ----------------------------------------------------------------------------
module tb_integer_text_parser;
   import itp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam logic [5:0] RADIX_BAD_LOW  = 6'd1;
   localparam logic [5:0] RADIX_BAD_HIGH = 6'd63;

   typedef struct {
      logic [63:0] value;
      logic        range_error;
      logic [15:0] end_offset;
   } number_result_type;

   typedef struct {
      logic [7:0] ch;
      logic       start;
      logic       pause;
   } char_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_ch = 8'h00;
   logic        req_start_req = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_value;
   logic        rsp_range_error;
   logic [15:0] rsp_end_offset;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_RADIX;
   logic [5:0]  csr_wdata = '0;

   integer_text_parser uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ch          (req_ch),
      .req_start_req   (req_start_req),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value       (rsp_value),
      .rsp_range_error (rsp_range_error),
      .rsp_end_offset  (rsp_end_offset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser model state and settings
   logic [5:0]       cfg_radix;
   logic             cfg_signed;
   phase_type        ps_phase;
   logic             ps_neg;
   logic [5:0]       ps_base;
   logic [63:0]      ps_acc;
   digit_status_type ps_dstat;
   logic [15:0]      ps_off;
   logic             ps_idle;

   number_result_type expected_numbers[$];
   char_word_type     pending_chars[$];
   int                stream_count = 0;
   int                fail_count = 0;
   int                cycle_count = 0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                hold_request = 0;
   int                hold_left = 0;
   logic              char_taken = 1'b0;

   function automatic int char_digit(logic [7:0] c, logic [5:0] base);
      int d;
      if (base < RADIX_MIN || base > RADIX_MAX) return -1;
      if (c >= "0" && c <= "9") d = c - "0";
      else if (c >= "A" && c <= "Z") d = c - UPPER_BIAS;
      else if (c >= "a" && c <= "z") d = c - LOWER_BIAS;
      else return -1;
      return (d < base) ? d : -1;
   endfunction

   task automatic take_digit(logic [5:0] d);
      logic [63:0] top, cut, rem;
      if (ps_dstat == DS_OVF) return;
      top = cfg_signed ? (ps_neg ? SMIN : SMAX) : WORD_MASK;
      cut = top / ps_base;
      rem = top % ps_base;
      if (ps_acc > cut || (ps_acc == cut && d > rem)) begin
         ps_dstat = DS_OVF;
      end else begin
         ps_dstat = DS_SEEN;
         ps_acc = ps_acc * ps_base + d;
      end
   endtask

   task automatic close_number(logic [15:0] endpos);
      number_result_type r;
      r.value = '0;
      r.range_error = 1'b0;
      r.end_offset = '0;
      if (ps_dstat == DS_OVF) begin
         r.range_error = 1'b1;
         r.value = cfg_signed ? (ps_neg ? SMIN : SMAX) : WORD_MASK;
         r.end_offset = endpos;
      end else if (ps_dstat == DS_SEEN) begin
         r.value = ps_neg ? (64'd0 - ps_acc) : ps_acc;
         r.end_offset = endpos;
      end
      expected_numbers.push_back(r);
      ps_idle = 1'b1;
   endtask

   task automatic parse_char(logic [7:0] c, logic st);
      logic        taken;
      int          d;
      logic [15:0] pos;
      taken = 1'b0;
      if (st) begin
         ps_phase = PH_SKIP;
         ps_neg = 1'b0;
         ps_base = '0;
         ps_acc = '0;
         ps_dstat = DS_NONE;
         ps_off = '0;
         ps_idle = 1'b0;
      end
      if (ps_idle) return;
      pos = ps_off;
      if (ps_phase == PH_SKIP) begin
         if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            taken = 1'b1;
         end else if (c == "+" || c == "-") begin
            ps_neg = (c == "-");
            ps_phase = PH_PREFIX;
            taken = 1'b1;
         end else begin
            ps_phase = PH_PREFIX;
         end
      end
      if (!taken && ps_phase == PH_PREFIX) begin
         if (c == "0" && (cfg_radix == RADIX_AUTO || cfg_radix == RADIX_HEX)) begin
            ps_acc = '0;
            ps_dstat = DS_SEEN;
            ps_phase = PH_ZERO;
            taken = 1'b1;
         end else begin
            ps_base = (cfg_radix == RADIX_AUTO) ? RADIX_DEC : cfg_radix;
            ps_phase = PH_DIGITS;
         end
      end
      if (!taken && ps_phase == PH_ZERO) begin
         if (c == "x" || c == "X") begin
            ps_base = RADIX_HEX;
            ps_phase = PH_HEXFIRST;
            taken = 1'b1;
         end else begin
            ps_base = (cfg_radix == RADIX_AUTO) ? RADIX_OCT : cfg_radix;
            ps_phase = PH_DIGITS;
         end
      end
      if (!taken && ps_phase == PH_HEXFIRST) begin
         // lone "0x": the zero is the number, the x is where it stopped
         if (char_digit(c, ps_base) < 0) begin
            close_number((pos == OFF_MAX) ? pos : pos - 1'b1);
            taken = 1'b1;
         end else begin
            ps_phase = PH_DIGITS;
         end
      end
      if (!taken) begin
         d = char_digit(c, ps_base);
         if (d < 0) close_number(pos);
         else take_digit(d[5:0]);
      end
      if (ps_off != OFF_MAX) ps_off = ps_off + 1'b1;
   endtask

   // ---------------------------------------------------------------- stimulus
   task automatic add_char(logic [7:0] c, logic s);
      pending_chars.push_back('{ch: c, start: s, pause: 1'b0});
      stream_count++;
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i], i == 0);
   endtask

   function automatic logic [7:0] ws_char();
      int k;
      k = $urandom_range(0, 5);
      return (k == 5) ? 8'h20 : 8'(9 + k);
   endfunction

   function automatic logic [7:0] digit_char(int d);
      if (d < 10) return 8'(d) + "0";
      return $urandom_range(0, 1) ? 8'(d) + LOWER_BIAS : 8'(d) + UPPER_BIAS;
   endfunction

   task automatic gen_number();
      logic [7:0]  text[$];
      int          digs[$];
      logic [63:0] v;
      logic        hexp, octp;
      int          b, n, maxlen;
      hexp = 1'b0;
      octp = 1'b0;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      repeat (n) text.push_back(ws_char());
      case ($urandom_range(0, 3))
         1: text.push_back("+");
         2: text.push_back("-");
         default: ;
      endcase
      if ((cfg_radix == RADIX_AUTO || cfg_radix == RADIX_HEX) && $urandom_range(0, 2) == 0) begin
         text.push_back("0");
         text.push_back($urandom_range(0, 1) ? "x" : "X");
         hexp = 1'b1;
      end else if (cfg_radix == RADIX_AUTO && $urandom_range(0, 2) == 0) begin
         text.push_back("0");
         octp = 1'b1;
      end
      if (cfg_radix == RADIX_AUTO) b = hexp ? 16 : (octp ? 8 : 10);
      else b = cfg_radix;
      if (b < 2 || b > 36) b = 36;
      if ($urandom_range(0, 4) == 0) begin
         // around the saturation limits
         case ($urandom_range(0, 2))
            0: v = SMAX;
            1: v = SMIN;
            default: v = WORD_MASK;
         endcase
         if ($urandom_range(0, 1)) v = v - 1;
         while (v != 0) begin
            digs.push_front(int'(v % b));
            v = v / b;
         end
         if ($urandom_range(0, 1) && digs[digs.size()-1] < b - 1)
            digs[digs.size()-1] = digs[digs.size()-1] + 1;
      end else begin
         maxlen = 0;
         v = WORD_MASK;
         while (v != 0) begin
            v = v / b;
            maxlen++;
         end
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, maxlen + 2) : $urandom_range(0, 4);
         repeat (n)
            digs.push_back(($urandom_range(0, 15) == 0) ? $urandom_range(0, 35)
                                                         : $urandom_range(0, b - 1));
      end
      foreach (digs[i]) text.push_back(digit_char(digs[i]));
      // occasionally leave it open so the next start cuts in
      if ($urandom_range(0, 11) != 0)
         text.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
      foreach (text[i]) add_char(text[i], i == 0);
      if ($urandom_range(0, 4) == 0) add_char(8'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic gen_noise();
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
         add_char(8'($urandom_range(0, 255)),
                  (i == 0) ? 1'($urandom_range(0, 1)) : 1'($urandom_range(0, 7) == 0));
   endtask

   task automatic random_stream(int target);
      int   first;
      logic paused;
      first = stream_count;
      paused = 1'b0;
      while (stream_count - first < target) begin
         if (!paused && stream_count - first >= target / 2) begin
            pending_chars.push_back('{ch: 8'h00, start: 1'b0, pause: 1'b1});
            paused = 1'b1;
         end
         if ($urandom_range(0, 4) == 0) gen_noise();
         else gen_number();
      end
      // NUL always closes an open string
      add_char(8'h00, 1'b0);
   endtask

   task automatic wait_drained();
      while (pending_chars.size() > 0 || req_valid || expected_numbers.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [5:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_RADIX) cfg_radix = data;
      else cfg_signed = data[0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(logic [5:0] radix, logic sgn, int sidle, int ridle);
      wait_drained();
      write_reg(CSR_RADIX, radix);
      write_reg(CSR_SIGNED, {5'd0, sgn});
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
   endtask

   // ---------------------------------------------------------------- driver
   always @(negedge clock) begin : drive_chars
      logic          nxt_valid;
      char_word_type w;
      nxt_valid = req_valid;
      if (reset) begin
         nxt_valid = 1'b0;
      end else if (!req_valid || char_taken) begin
         char_taken = 1'b0;
         nxt_valid = 1'b0;
         if (pending_chars.size() > 0 && pending_chars[0].pause && expected_numbers.size() == 0)
            void'(pending_chars.pop_front());
         if (pending_chars.size() > 0 && !pending_chars[0].pause &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            w = pending_chars.pop_front();
            req_ch <= w.ch;
            req_start_req <= w.start;
            nxt_valid = 1'b1;
         end
      end
      req_valid <= nxt_valid;
   end

   always @(negedge clock) begin : pace_results
      if (hold_left == 0 && hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin : watch_ports
      number_result_type e;
      if (!reset) begin
         if (req_valid && req_ready) begin
            char_taken = 1'b1;
            parse_char(req_ch, req_start_req);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_numbers.size() == 0) begin
               $error("unexpected result word: value %h", rsp_value);
               fail_count++;
            end else begin
               e = expected_numbers.pop_front();
               if (rsp_value !== e.value) begin
                  $error("value: expected %h, got %h", e.value, rsp_value);
                  fail_count++;
               end
               if (rsp_range_error !== e.range_error) begin
                  $error("range_error: expected %b, got %b", e.range_error, rsp_range_error);
                  fail_count++;
               end
               if (rsp_end_offset !== e.end_offset) begin
                  $error("end_offset: expected %0d, got %0d", e.end_offset, rsp_end_offset);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      cfg_radix = RADIX_DEC;
      cfg_signed = 1'b1;
      ps_phase = PH_SKIP;
      ps_neg = 1'b0;
      ps_base = '0;
      ps_acc = '0;
      ps_dstat = DS_NONE;
      ps_off = '0;
      ps_idle = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      configure(RADIX_AUTO, 1'b1, 14, 57);
      add_text("\t+7,");
      add_text("0xg");
      add_text("0179");
      add_text("-0X1f");
      add_char(8'h00, 1'b0);
      add_char("A", 1'b0);               // dropped, parser idle
      add_text("+ ");
      add_char(8'hFF, 1'b1);
      add_text("12");
      add_char("3", 1'b1);               // restart mid-string
      add_char(8'h00, 1'b0);
      random_stream(130);

      configure(RADIX_DEC, 1'b1, 14, 57);
      random_stream(155);
      configure(RADIX_DEC, 1'b0, 14, 57);
      random_stream(155);

      configure(RADIX_HEX, 1'b1, 57, 14);
      random_stream(155);
      configure(RADIX_MAX, 1'b0, 57, 14);
      random_stream(155);
      configure(RADIX_MIN, 1'b1, 57, 14);
      random_stream(155);
      configure(RADIX_BAD_LOW, 1'b0, 57, 14);
      random_stream(100);

      configure(RADIX_OCT, 1'b0, 0, 0);
      hold_request = 400;
      random_stream(155);
      configure(RADIX_BAD_HIGH, 1'b1, 0, 0);
      random_stream(100);
      configure(RADIX_AUTO, 1'b0, 0, 0);
      random_stream(155);

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
